FILE: rtl/assert_macros.svh
// Assertion macros shared by the merge selector RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent holds in a cycle, so the consequent holds in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent holds in a cycle, so the consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/kms_pkg.sv
// Types and constants shared by the k-way merge selector.
package kms_pkg;

  localparam int SOURCES_DEF  = 16;
  localparam int KEY_BITS_DEF = 64;

  // Fixed field widths of the item and result transfers.
  localparam int SRC_W   = 4;
  localparam int KEY_W   = 64;
  localparam int SRC_IDS = 2 ** SRC_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int SC_W       = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_UNIQUE_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_COUNT = 1'd1;

  localparam logic [SC_W-1:0] SOURCE_COUNT_RESET = 5'd2;

  typedef struct packed {
    logic [SRC_W-1:0] source;
    logic [KEY_W-1:0] key;
    logic             ended;
  } item_t;

  typedef struct packed {
    logic             emitted;
    logic [SRC_W-1:0] chosen_source;
    logic [KEY_W-1:0] chosen_key;
    logic             keep;
    logic             finished;
  } result_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     at_fill;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_PLACE
  } state_t;

endpackage

FILE: rtl/kms_cell.sv
// One slot of the ordered source list: holds a source and its head key.
`include "assert_macros.svh"

module kms_cell #(
  parameter int KEY_BITS = kms_pkg::KEY_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  kms_pkg::cell_ctl_t       ctl,
  input  logic [KEY_BITS-1:0]      ins_key,
  input  logic [kms_pkg::SRC_W-1:0] ins_src,
  input  logic                     prev_valid,
  input  logic                     prev_ahead,
  input  logic [kms_pkg::SRC_W-1:0] prev_src,
  input  logic [KEY_BITS-1:0]      prev_key,
  input  logic                     next_valid,
  input  logic [kms_pkg::SRC_W-1:0] next_src,
  input  logic [KEY_BITS-1:0]      next_key,
  output logic                     valid,
  output logic [kms_pkg::SRC_W-1:0] src,
  output logic [KEY_BITS-1:0]      key,
  output logic                     ahead
);

  // An entry stays in front of the new one if its key is smaller; at fill an
  // equal key with a lower source index also stays in front.
  always_comb begin
    ahead = valid && ((key < ins_key) ||
                      (ctl.at_fill && (key == ins_key) && (src < ins_src)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (ctl.op)
        kms_pkg::OP_INSERT: begin
          if (!ahead) begin
            valid <= prev_ahead ? 1'b1 : prev_valid;
          end
        end
        kms_pkg::OP_POP: begin
          valid <= next_valid;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      kms_pkg::OP_INSERT: begin
        if (!ahead) begin
          if (prev_ahead) begin
            src <= ins_src;
            key <= ins_key;
          end else begin
            src <= prev_src;
            key <= prev_key;
          end
        end
      end
      kms_pkg::OP_POP: begin
        src <= next_src;
        key <= next_key;
      end
      default: begin
      end
    endcase
  end

  `ASSERT_SAME(a_cell_sorted, clk, rst, valid && prev_valid, prev_key <= key, "list out of key order")

endmodule

FILE: rtl/kway_merge_selector.sv
// Top level of the k-way merge selector: control, configuration and the cell row.
// Fill items: no result until the last one; its result is loaded into the output register at that transfer.
// Running phase: each replacement item pops the front of the cell row at its transfer; PLACE then
// inserts it and loads its result once the output register is free, so no new item is taken until
// it is placed; a stalled result holds the next item transfer back until the result transfer has happened.
// Reset (rst, synchronous, active high): empty list, fill phase, unique_mode 0, source_count 2.
`include "assert_macros.svh"

module kway_merge_selector #(
  parameter int SOURCES  = kms_pkg::SOURCES_DEF,
  parameter int KEY_BITS = kms_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  kms_pkg::item_t                item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output kms_pkg::result_t              result,
  input  logic                          cfg_write,
  input  logic [kms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kms_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Counters must hold both SOURCES and any source_count value.
  localparam int CNT_W = ($clog2(SOURCES + 1) > kms_pkg::SC_W) ?
                         $clog2(SOURCES + 1) : kms_pkg::SC_W;
  localparam logic [CNT_W-1:0] SOURCES_C = CNT_W'(SOURCES);

  // Configuration registers.
  logic                    unique_mode;
  logic [kms_pkg::SC_W-1:0] source_count;

  // Merge control state.
  kms_pkg::state_t              state, state_next;
  logic                         running;
  logic [CNT_W-1:0]             fill_count;
  logic [kms_pkg::SRC_IDS-1:0]  live;
  logic [KEY_BITS-1:0]          prev_key;
  logic                         first_pending;

  // The replacement taken in the running phase, placed in PLACE once the output register is free.
  logic [kms_pkg::SRC_W-1:0]    pend_src;
  logic [KEY_BITS-1:0]          pend_key;
  logic                         pend_ended;

  // The cell row. Cell 0 is the front of the list.
  logic                         c_valid [SOURCES];
  logic [kms_pkg::SRC_W-1:0]    c_src   [SOURCES];
  logic [KEY_BITS-1:0]          c_key   [SOURCES];
  logic                         c_ahead [SOURCES];

  kms_pkg::cell_ctl_t           ctl;
  logic [KEY_BITS-1:0]          ins_key;
  logic [kms_pkg::SRC_W-1:0]    ins_src;

  logic                         slot_free;
  logic                         item_take;
  logic [CNT_W-1:0]             cnt_used;
  logic [CNT_W-1:0]             sc_ext;
  logic [CNT_W-1:0]             fill_inc;
  logic                         fill_done;
  logic [KEY_BITS-1:0]          item_key;
  logic                         do_ins;

  // Result loading, shared by the end of fill and the running phase.
  logic                         load_res;
  logic                         front_valid;
  logic [kms_pkg::SRC_W-1:0]    front_src;
  logic [KEY_BITS-1:0]          front_key;
  logic                         keep_bit;

  // The output register is free when empty or when its transfer happens now.
  assign slot_free = !result_valid || !result_stall;
  assign item_take = item_valid && !item_stall;
  assign item_key  = item.key[KEY_BITS-1:0];

  // The source count in use is clamped to the range one to SOURCES.
  assign sc_ext    = CNT_W'(source_count);
  assign cnt_used  = (sc_ext == '0) ? CNT_W'(1) : ((sc_ext > SOURCES_C) ? SOURCES_C : sc_ext);
  assign fill_inc  = fill_count + CNT_W'(1);
  assign fill_done = (fill_inc >= cnt_used);

  // A fill item places its source only if it is in range, not yet live and not ended.
  assign do_ins = (CNT_W'(item.source) < cnt_used) && !live[item.source] && !item.ended;

  // Next-state logic. An item is taken only in IDLE; a running-phase item then moves to PLACE,
  // which places the replacement once the output register is free.
  always_comb begin
    state_next = state;
    case (state)
      kms_pkg::ST_IDLE: begin
        if (item_take && running) begin
          state_next = kms_pkg::ST_PLACE;
        end
      end
      kms_pkg::ST_PLACE: begin
        if (slot_free) begin
          state_next = kms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = kms_pkg::ST_IDLE;
      end
    endcase
  end

  // Output logic: the command to the cell row and the result load.
  always_comb begin
    item_stall  = 1'b1;
    ctl.op      = kms_pkg::OP_HOLD;
    ctl.at_fill = 1'b0;
    ins_key     = pend_key;
    ins_src     = pend_src;
    load_res    = 1'b0;
    front_valid = c_valid[0];
    front_src   = c_src[0];
    front_key   = c_key[0];
    case (state)
      kms_pkg::ST_IDLE: begin
        item_stall = !slot_free;
        if (!running) begin
          // Fill: place the head record in the same cycle as its transfer.
          ctl.at_fill = 1'b1;
          ins_key     = item_key;
          ins_src     = item.source;
          if (item_take) begin
            if (do_ins) begin
              ctl.op = kms_pkg::OP_INSERT;
            end
            load_res    = fill_done;
            front_valid = do_ins || c_valid[0];
            if (do_ins && !c_ahead[0]) begin
              front_src = item.source;
              front_key = item_key;
            end
          end
        end else if (item_take) begin
          // Running: the emitted source leaves the front of the list.
          ctl.op = kms_pkg::OP_POP;
        end
      end
      kms_pkg::ST_PLACE: begin
        if (slot_free) begin
          if (!pend_ended) begin
            ctl.op = kms_pkg::OP_INSERT;
          end
          load_res    = 1'b1;
          front_valid = !pend_ended || c_valid[0];
          if (!pend_ended && !c_ahead[0]) begin
            front_src = pend_src;
            front_key = pend_key;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // A key equal to the last emitted one is dropped in unique mode, never on the first emission.
  assign keep_bit = !(unique_mode && !first_pending && (front_key == prev_key));

  genvar i;
  generate
    for (i = 0; i < SOURCES; i++) begin : g_cell
      logic                      p_valid;
      logic                      p_ahead;
      logic [kms_pkg::SRC_W-1:0] p_src;
      logic [KEY_BITS-1:0]       p_key;
      logic                      n_valid;
      logic [kms_pkg::SRC_W-1:0] n_src;
      logic [KEY_BITS-1:0]       n_key;

      if (i == 0) begin : g_head
        // Nothing stands before the front cell, so a new entry may always go there.
        assign p_valid = 1'b0;
        assign p_ahead = 1'b1;
        assign p_src   = '0;
        assign p_key   = '0;
      end else begin : g_body
        assign p_valid = c_valid[i-1];
        assign p_ahead = c_ahead[i-1];
        assign p_src   = c_src[i-1];
        assign p_key   = c_key[i-1];
      end

      if (i == SOURCES - 1) begin : g_tail
        assign n_valid = 1'b0;
        assign n_src   = '0;
        assign n_key   = '0;
      end else begin : g_link
        assign n_valid = c_valid[i+1];
        assign n_src   = c_src[i+1];
        assign n_key   = c_key[i+1];
      end

      kms_cell #(
        .KEY_BITS(KEY_BITS)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .ins_key   (ins_key),
        .ins_src   (ins_src),
        .prev_valid(p_valid),
        .prev_ahead(p_ahead),
        .prev_src  (p_src),
        .prev_key  (p_key),
        .next_valid(n_valid),
        .next_src  (n_src),
        .next_key  (n_key),
        .valid     (c_valid[i]),
        .src       (c_src[i]),
        .key       (c_key[i]),
        .ahead     (c_ahead[i])
      );
    end
  endgenerate

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      unique_mode  <= 1'b0;
      source_count <= kms_pkg::SOURCE_COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        kms_pkg::CFG_UNIQUE_MODE:  unique_mode  <= cfg_data[0];
        kms_pkg::CFG_SOURCE_COUNT: source_count <= cfg_data[kms_pkg::SC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Control state. A finish clears everything back to the fill phase; the cells are
  // already empty at that point.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= kms_pkg::ST_IDLE;
      running       <= 1'b0;
      fill_count    <= '0;
      live          <= '0;
      prev_key      <= '0;
      first_pending <= 1'b1;
      result_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (load_res && !front_valid) begin
        running       <= 1'b0;
        fill_count    <= '0;
        live          <= '0;
        prev_key      <= '0;
        first_pending <= 1'b1;
      end else begin
        if (item_take && !running) begin
          fill_count <= fill_inc;
          if (do_ins) begin
            live[item.source] <= 1'b1;
          end
          if (fill_done) begin
            running <= 1'b1;
          end
        end

        if (item_take && running && item.ended) begin
          live[c_src[0]] <= 1'b0;
        end

        if (load_res) begin
          prev_key      <= front_key;
          first_pending <= 1'b0;
        end
      end

      if (load_res) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (item_take && running) begin
      pend_src   <= c_src[0];
      pend_key   <= item_key;
      pend_ended <= item.ended;
    end
    if (load_res) begin
      result.emitted       <= front_valid;
      result.finished      <= !front_valid;
      result.chosen_source <= front_valid ? front_src : '0;
      result.chosen_key    <= front_valid ? kms_pkg::KEY_W'(front_key) : '0;
      result.keep          <= front_valid && keep_bit;
    end
  end

  `ASSERT_NEXT(a_finish_clears, clk, rst, load_res && !front_valid,
               !running && (live == '0), "finish did not return to fill")
  `ASSERT_SAME(a_front_live, clk, rst, c_valid[0], live[c_src[0]],
               "front of list is not a live source")
  `ASSERT_NEXT(a_place_loads, clk, rst, (state == kms_pkg::ST_PLACE) && slot_free,
               result_valid, "placement gave no result")
  `ASSERT_SAME(a_finished_zero, clk, rst, result_valid && result.finished,
               !result.emitted && (result.chosen_key == '0) && !result.keep,
               "finished result carries data")

endmodule

FILE: sim/kway_merge_selector_tb.sv
// Self-checking testbench for the k-way merge selector: directed merges, then random phases.
module kway_merge_selector_tb;
  import kms_pkg::*;

  localparam int NUM_SOURCES    = SOURCES_DEF;
  localparam int RESET_CYCLES   = 8;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 120;
  localparam int STREAM_MAX     = 6;

  typedef logic [4:0] link_t;
  localparam link_t LINK_NONE = 5'h1F;

  // Predicts the merge order and holds the results still owed by the block.
  class merge_scoreboard;
    bit               unique_on;
    logic [SC_W-1:0]  count_reg;
    logic [KEY_W-1:0] head_key [NUM_SOURCES];
    link_t            next_link [NUM_SOURCES];
    bit               live [NUM_SOURCES];
    link_t            front_src;
    logic [KEY_W-1:0] last_key;
    bit               first_pending;
    int               filled;
    bit               running;
    result_t          expected_q [$];
    int               errors;
    int               items_seen;
    int               records;
    int               dropped;
    int               merges;

    function new();
      unique_on = 1'b0;
      count_reg = SOURCE_COUNT_RESET;
      foreach (head_key[i]) head_key[i] = '0;
      clear_list();
      errors = 0;
      items_seen = 0;
      records = 0;
      dropped = 0;
      merges = 0;
    endfunction

    function void clear_list();
      foreach (next_link[i]) begin
        next_link[i] = LINK_NONE;
        live[i] = 1'b0;
      end
      front_src = LINK_NONE;
      last_key = '0;
      first_pending = 1'b1;
      filled = 0;
      running = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_UNIQUE_MODE: unique_on = data[0];
        CFG_SOURCE_COUNT: count_reg = data[SC_W-1:0];
        default: ;
      endcase
    endfunction

    function int used_count();
      if (count_reg < 1) return 1;
      if (count_reg > NUM_SOURCES) return NUM_SOURCES;
      return int'(count_reg);
    endfunction

    function bit in_fill();
      return !running;
    endfunction

    function link_t front();
      return front_src;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Walks the list to the first entry that the new key sorts before. At fill a tie goes
    // to the lower source; on replacement the replaced source goes ahead of equal keys.
    function void place(int s, bit at_fill);
      link_t            prev;
      link_t            cur;
      logic [KEY_W-1:0] k;
      prev = LINK_NONE;
      cur = front_src;
      k = head_key[s];
      while (cur != LINK_NONE) begin
        if (head_key[cur] > k || (head_key[cur] == k && (!at_fill || cur > s))) break;
        prev = cur;
        cur = next_link[cur];
      end
      next_link[s] = cur;
      if (prev == LINK_NONE) front_src = link_t'(s);
      else next_link[prev] = link_t'(s);
    endfunction

    function result_t finish_merge();
      result_t r;
      r = '0;
      r.finished = 1'b1;
      clear_list();
      return r;
    endfunction

    function result_t emit_front();
      result_t r;
      r = '0;
      r.emitted = 1'b1;
      r.chosen_source = front_src[SRC_W-1:0];
      r.chosen_key = head_key[front_src];
      r.keep = !(unique_on && !first_pending && head_key[front_src] == last_key);
      first_pending = 1'b0;
      last_key = head_key[front_src];
      return r;
    endfunction

    // Applies one input item; returns 1 when the item causes a result.
    function bit advance(item_t it, output result_t r);
      int    cnt;
      int    s;
      link_t f;
      r = '0;
      if (!running) begin
        cnt = used_count();
        s = int'(it.source);
        if (s < cnt && !live[s] && !it.ended) begin
          head_key[s] = it.key;
          live[s] = 1'b1;
          place(s, 1'b1);
        end
        filled++;
        if (filled < cnt) return 1'b0;
        running = 1'b1;
        r = (front_src == LINK_NONE) ? finish_merge() : emit_front();
        return 1'b1;
      end
      if (front_src == LINK_NONE) begin
        r = finish_merge();
        return 1'b1;
      end
      f = front_src;
      front_src = next_link[f];
      next_link[f] = LINK_NONE;
      if (it.ended) begin
        live[f] = 1'b0;
      end else begin
        head_key[f] = it.key;
        place(int'(f), 1'b0);
      end
      r = (front_src == LINK_NONE) ? finish_merge() : emit_front();
      return 1'b1;
    endfunction

    function void note_item(item_t it);
      result_t r;
      items_seen++;
      if (advance(it, r)) expected_q.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_q.size() == 0) begin
        $error("result: no transfer expected, got emitted=%0b finished=%0b",
               got.emitted, got.finished);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.emitted !== exp.emitted) begin
        $error("emitted: expected %0h, actual %0h", exp.emitted, got.emitted);
        errors++;
      end
      if (got.chosen_source !== exp.chosen_source) begin
        $error("chosen_source: expected %0h, actual %0h", exp.chosen_source, got.chosen_source);
        errors++;
      end
      if (got.chosen_key !== exp.chosen_key) begin
        $error("chosen_key: expected %0h, actual %0h", exp.chosen_key, got.chosen_key);
        errors++;
      end
      if (got.keep !== exp.keep) begin
        $error("keep: expected %0h, actual %0h", exp.keep, got.keep);
        errors++;
      end
      if (got.finished !== exp.finished) begin
        $error("finished: expected %0h, actual %0h", exp.finished, got.finished);
        errors++;
      end
      if (exp.emitted) begin
        records++;
        if (!exp.keep) dropped++;
      end
      if (exp.finished) merges++;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  item_valid;
  logic                  item_stall;
  item_t                 item;
  logic                  result_valid;
  logic                  result_stall;
  result_t               result;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  merge_scoreboard sb;
  merge_scoreboard planner;  // a second copy, used to know which source each replacement is for
  item_t           item_q [$];
  int              send_idle = 0;
  int              stall_pct = 0;
  bit              hold_req = 1'b0;

  kway_merge_selector dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Every transfer is sampled at the clock edge, before the block's registers move.
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) sb.note_item(item);
      if (result_valid && !result_stall) sb.check_result(result);
    end
  end

  // Result side: random stalls, or one long hold-off when asked for.
  initial begin : receiver
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      result_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  function automatic item_t mk_item(int src, logic [KEY_W-1:0] k, bit e);
    item_t it;
    it.source = SRC_W'(src);
    it.key = k;
    it.ended = e;
    return it;
  endfunction

  function automatic logic [KEY_W-1:0] random_key(bit narrow);
    if (narrow) return KEY_W'($urandom_range(0, 6));
    return {$urandom(), $urandom()};
  endfunction

  // Next key of a sorted stream; saturates at the top of the key range.
  function automatic logic [KEY_W-1:0] step_key(logic [KEY_W-1:0] k, bit narrow);
    logic [KEY_W-1:0] inc;
    logic [KEY_W-1:0] sum;
    if (narrow) inc = KEY_W'($urandom_range(0, 2));
    else inc = {$urandom(), $urandom()} >> $urandom_range(4, 63);
    sum = k + inc;
    return (sum < k) ? '1 : sum;
  endfunction

  // Appends one complete merge to item_q. Mostly sorted streams with random content; one in
  // four merges is noise: random fill sources, unsorted keys and early ends.
  function automatic void plan_merge();
    logic [KEY_W-1:0] stream_key [NUM_SOURCES][STREAM_MAX];
    int               stream_len [NUM_SOURCES];
    int               stream_pos [NUM_SOURCES];
    int               order [NUM_SOURCES];
    bit               noisy;
    bit               narrow;
    bit               got;
    int               cnt;
    int               fill_i;
    int               run_i;
    int               j;
    int               t;
    link_t            f;
    logic [KEY_W-1:0] k;
    item_t            it;
    result_t          r;
    noisy = ($urandom_range(0, 3) == 0);
    narrow = 1'($urandom_range(0, 1));
    cnt = planner.used_count();
    for (int s = 0; s < NUM_SOURCES; s++) begin
      stream_len[s] = $urandom_range(0, STREAM_MAX);
      stream_pos[s] = 0;
      order[s] = s;
      k = random_key(narrow);
      if (!narrow && $urandom_range(0, 7) == 0) k = '1 - KEY_W'($urandom_range(0, 20));
      for (int n = 0; n < STREAM_MAX; n++) begin
        stream_key[s][n] = k;
        k = step_key(k, narrow);
      end
    end
    for (int s = cnt - 1; s > 0; s--) begin
      j = $urandom_range(0, s);
      t = order[s];
      order[s] = order[j];
      order[j] = t;
    end
    fill_i = 0;
    run_i = 0;
    do begin
      it.source = SRC_W'($urandom_range(0, 15));
      it.key = random_key(narrow);
      it.ended = 1'b0;
      if (planner.in_fill()) begin
        if (noisy) begin
          it.ended = ($urandom_range(0, 4) == 0);
        end else begin
          it.source = SRC_W'(order[fill_i]);
          if (stream_len[order[fill_i]] == 0) begin
            it.ended = 1'b1;
          end else begin
            it.key = stream_key[order[fill_i]][0];
            stream_pos[order[fill_i]] = 1;
          end
        end
        fill_i++;
      end else begin
        f = planner.front();
        if (noisy) begin
          it.ended = (run_i >= 30) || ($urandom_range(0, 2) == 0);
        end else if (stream_pos[f] < stream_len[f]) begin
          it.key = stream_key[f][stream_pos[f]];
          stream_pos[f]++;
        end else begin
          it.ended = 1'b1;
        end
        run_i++;
      end
      got = planner.advance(it, r);
      item_q.push_back(it);
    end while (!(got && r.finished));
  endfunction

  // Both registers in back-to-back cycles, so cfg_write is raised and lowered only once.
  task automatic write_regs(input logic [CFG_DATA_W-1:0] unique_data,
                            input logic [CFG_DATA_W-1:0] count_data);
    cfg_write <= 1'b1;
    cfg_index <= CFG_UNIQUE_MODE;
    cfg_data  <= unique_data;
    @(posedge clk);
    cfg_index <= CFG_SOURCE_COUNT;
    cfg_data  <= count_data;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.write_reg(CFG_UNIQUE_MODE, unique_data);
    sb.write_reg(CFG_SOURCE_COUNT, count_data);
    planner.write_reg(CFG_UNIQUE_MODE, unique_data);
    planner.write_reg(CFG_SOURCE_COUNT, count_data);
  endtask

  // Offers every queued item, then waits until all results are in and the block is quiet.
  task automatic run_phase(input int idle_pct, input int stall_in, input bit hold,
                           input bit pause);
    int pause_at;
    send_idle = idle_pct;
    stall_pct = stall_in;
    if (hold) hold_req = 1'b1;
    pause_at = pause ? item_q.size() / 2 : -1;
    for (int n = 0; n < item_q.size(); n++) begin
      if (n == pause_at) begin
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      while ($urandom_range(0, 99) < send_idle) begin
        item_valid <= 1'b0;
        @(posedge clk);
      end
      item_valid <= 1'b1;
      item <= item_q[n];
      @(posedge clk);
      while (item_stall) @(posedge clk);
    end
    item_valid <= 1'b0;
    item_q.delete();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] unique_data;
    logic [CFG_DATA_W-1:0] count_data;
    sb = new();
    planner = new();
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings, two sources: fill out of order with the extreme keys, then a
    // replacement that ties with an older source and must go ahead of it.
    item_q.push_back(mk_item(1, '1, 1'b0));
    item_q.push_back(mk_item(0, '0, 1'b0));
    item_q.push_back(mk_item(9, '1, 1'b0));
    item_q.push_back(mk_item(3, '0, 1'b1));
    item_q.push_back(mk_item(0, '0, 1'b1));
    run_phase(0, 0, 1'b0, 1'b0);

    // Unique mode, three sources: a three-way tie at fill, repeated keys, a source named twice
    // at fill, one out of range, and a fill in which every source is empty.
    write_regs(5'd1, 5'd3);
    item_q.push_back(mk_item(2, 64'd5, 1'b0));
    item_q.push_back(mk_item(0, 64'd5, 1'b0));
    item_q.push_back(mk_item(1, 64'd5, 1'b0));
    item_q.push_back(mk_item(4, 64'd5, 1'b0));
    item_q.push_back(mk_item(0, 64'd0, 1'b1));
    item_q.push_back(mk_item(8, 64'd7, 1'b0));
    item_q.push_back(mk_item(2, 64'd0, 1'b1));
    item_q.push_back(mk_item(1, 64'd0, 1'b1));
    item_q.push_back(mk_item(1, 64'd4, 1'b0));
    item_q.push_back(mk_item(1, 64'd2, 1'b0));
    item_q.push_back(mk_item(15, 64'd1, 1'b0));
    item_q.push_back(mk_item(6, 64'd0, 1'b1));
    item_q.push_back(mk_item(0, 64'd9, 1'b1));
    item_q.push_back(mk_item(1, '1, 1'b1));
    item_q.push_back(mk_item(2, 64'd3, 1'b1));
    run_phase(0, 0, 1'b0, 1'b0);

    // A source count of zero is taken as one.
    write_regs(5'b10101, 5'd0);
    item_q.push_back(mk_item(7, 64'd3, 1'b0));
    item_q.push_back(mk_item(0, '1, 1'b0));
    item_q.push_back(mk_item(9, '0, 1'b1));
    run_phase(0, 0, 1'b0, 1'b0);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin unique_data = 5'd1; count_data = 5'd16; end
        1: begin unique_data = {4'($urandom()), 1'b0}; count_data = 5'd31; end
        2: begin unique_data = 5'd1; count_data = 5'd1; end
        3: begin unique_data = 5'd0; count_data = 5'd5; end
        4: begin unique_data = 5'd1; count_data = 5'($urandom_range(1, 16)); end
        5: begin unique_data = {4'($urandom()), 1'b1}; count_data = 5'd2; end
        6: begin unique_data = 5'd0; count_data = 5'd8; end
        default: begin unique_data = 5'd1; count_data = 5'($urandom_range(17, 31)); end
      endcase
      write_regs(unique_data, count_data);
      while (item_q.size() < PHASE_ITEMS) plan_merge();
      case (p % 4)
        0: run_phase(0, 0, p == 0, 1'b0);
        1: run_phase(61, 0, 1'b0, 1'b0);
        2: run_phase(0, 61, 1'b0, 1'b0);
        default: run_phase(7, 7, 1'b0, 1'b1);
      endcase
    end

    $display("Merged %0d input items into %0d records (%0d marked as repeats) over %0d merges.",
             sb.items_seen, sb.records, sb.dropped, sb.merges);
    $display("Source counts from 0 to 31, both unique settings, all idling mixes, a hold-off.");
    if (sb.errors == 0 && sb.pending() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
